// ===== src/cmd_load_record_parser_assert.svh =====
// Assertion macros used by the record parser checker.
`ifndef CMD_LOAD_RECORD_PARSER_ASSERT_SVH
`define CMD_LOAD_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CLRP_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define CLRP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/clrp_pkg.sv =====
// Types and constants for the load-module record parser.
`default_nettype none

package clrp_pkg;

    // Record type bytes
    localparam logic [7:0] TYPE_LOAD  = 8'h01;
    localparam logic [7:0] TYPE_START = 8'h02;
    localparam logic [7:0] TYPE_NAME  = 8'h05;

    // Load record length byte carries two extra counts
    localparam logic [7:0] LOAD_LEN_BIAS = 8'h02;
    localparam logic [8:0] LOAD_LEN_FULL = 9'h100;

    // Result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_TYPE   = 3'd0,
        PH_LEN    = 3'd1,
        PH_NAME   = 3'd2,
        PH_LADDR  = 3'd3,
        PH_LDATA  = 3'd4,
        PH_START  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        RK_NONE  = 2'd0,
        RK_NAME  = 2'd1,
        RK_LOAD  = 2'd2,
        RK_START = 2'd3
    } rec_kind_t;

    typedef enum logic [2:0] {
        EV_NAME_BYTE  = 3'd0,
        EV_NAME_END   = 3'd1,
        EV_LOAD_BLOCK = 3'd2,
        EV_START_ADDR = 3'd3,
        EV_UNKNOWN    = 3'd4,
        EV_CLEAN_END  = 3'd5,
        EV_TRUNC_END  = 3'd6
    } ev_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  event_byte;
        logic [15:0] first_address;
        logic [16:0] end_address;
        logic        last_of_run;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== src/cmd_load_record_parser.sv =====
// Load-module record parser: byte stream in, record events out.
//
//  Channel | Direction | Handshake          | Beat
//  s_      | in        | s_valid / s_ready  | in_beat_t  (one file byte or end mark)
//  m_      | out       | m_valid / m_ready  | out_beat_t (one event)
//
// One input beat per cycle. A beat is held in the input register, then its state
// update and up to two events are formed in a single pass and pushed into a
// four-entry event queue; the queue drains one event per cycle while m_ready is high.
// Input stalls only while the queue holds more than two events.
// aresetn is synchronous, active low; it empties both stages and returns the
// parser to waiting for a record type byte.
`default_nettype none

module cmd_load_record_parser (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  clrp_pkg::in_beat_t    s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output clrp_pkg::out_beat_t   m_data
);
    import clrp_pkg::*;

    // Input register
    logic     in_valid_reg, in_valid_next;
    in_beat_t in_beat_reg;

    // Parser state
    phase_t    phase_reg, phase_next;
    rec_kind_t kind_reg, kind_next;
    logic [8:0]  left_reg, left_next;
    logic [8:0]  blen_reg, blen_next;
    logic [15:0] addr_reg, addr_next;
    logic [1:0]  pidx_reg, pidx_next;
    logic        halt_reg, halt_next;

    // Event queue
    out_beat_t            queue_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] count_reg;

    // Per-beat results
    logic       proc_fire;
    logic       pop;
    logic [1:0] n_res;
    out_beat_t  res0, res1;
    logic [7:0] b;
    logic [7:0] len8;
    logic [8:0] left_dec;

    assign b        = in_beat_reg.data_byte;
    assign len8     = b - LOAD_LEN_BIAS;
    assign left_dec = left_reg - 9'd1;

    assign proc_fire = in_valid_reg && (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign s_ready   = !in_valid_reg || proc_fire;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !proc_fire);

    assign m_valid = (count_reg != '0);
    assign m_data  = queue_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
    end

    // Parser state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            kind_reg  <= RK_NONE;
            left_reg  <= '0;
            blen_reg  <= '0;
            addr_reg  <= '0;
            pidx_reg  <= '0;
            halt_reg  <= 1'b0;
        end else if (proc_fire) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            blen_reg  <= blen_next;
            addr_reg  <= addr_next;
            pidx_reg  <= pidx_next;
            halt_reg  <= halt_next;
        end
    end

    // Next state and events for the beat in the input register
    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        blen_next  = blen_reg;
        addr_next  = addr_reg;
        pidx_next  = pidx_reg;
        halt_next  = halt_reg;
        n_res      = 2'd0;
        res0       = '0;
        res1       = '0;
        res1.event_kind  = EV_NAME_END;
        res1.last_of_run = 1'b1;

        if (in_beat_reg.end_of_stream) begin
            // End mark: report and fall back to reset state
            n_res = 2'd1;
            res0.event_kind = (halt_reg || phase_reg == PH_TYPE) ? EV_CLEAN_END
                                                                 : EV_TRUNC_END;
            phase_next = PH_TYPE;
            kind_next  = RK_NONE;
            left_next  = '0;
            blen_next  = '0;
            addr_next  = '0;
            pidx_next  = '0;
            halt_next  = 1'b0;
        end else if (!halt_reg) begin
            unique case (phase_reg)
                PH_TYPE: begin
                    priority if (b == TYPE_NAME) begin
                        kind_next  = RK_NAME;
                        phase_next = PH_LEN;
                    end else if (b == TYPE_LOAD) begin
                        kind_next  = RK_LOAD;
                        phase_next = PH_LEN;
                    end else if (b == TYPE_START) begin
                        kind_next  = RK_START;
                        phase_next = PH_LEN;
                    end else begin
                        halt_next = 1'b1;
                        n_res     = 2'd1;
                        res0.event_kind = EV_UNKNOWN;
                        res0.event_byte = b;
                    end
                end
                PH_LEN: begin
                    addr_next = '0;
                    pidx_next = '0;
                    unique case (kind_reg)
                        RK_NAME: begin
                            if (b == '0) begin
                                n_res = 2'd1;
                                res0.event_kind = EV_NAME_END;
                                phase_next = PH_TYPE;
                            end else begin
                                left_next  = {1'b0, b};
                                phase_next = PH_NAME;
                            end
                        end
                        RK_LOAD: begin
                            // zero length stands for a full 256-byte block
                            blen_next  = (len8 == '0) ? LOAD_LEN_FULL : {1'b0, len8};
                            left_next  = (len8 == '0) ? LOAD_LEN_FULL : {1'b0, len8};
                            phase_next = PH_LADDR;
                        end
                        RK_START: begin
                            if (b == '0) begin
                                n_res = 2'd1;
                                res0.event_kind = EV_START_ADDR;
                                phase_next = PH_TYPE;
                            end else begin
                                left_next  = {1'b0, b};
                                phase_next = PH_START;
                            end
                        end
                        default: begin
                            phase_next = PH_TYPE;
                        end
                    endcase
                end
                PH_NAME: begin
                    n_res = 2'd1;
                    res0.event_kind = EV_NAME_BYTE;
                    res0.event_byte = b;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        n_res = 2'd2;
                        phase_next = PH_TYPE;
                    end
                end
                PH_LADDR: begin
                    // little-endian block start
                    if (pidx_reg == 2'd0) begin
                        addr_next = {8'h00, b};
                        pidx_next = 2'd1;
                    end else begin
                        addr_next  = {b, addr_reg[7:0]};
                        pidx_next  = 2'd2;
                        phase_next = PH_LDATA;
                    end
                end
                PH_LDATA: begin
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        n_res = 2'd1;
                        res0.event_kind    = EV_LOAD_BLOCK;
                        res0.first_address = addr_reg;
                        res0.end_address   = {1'b0, addr_reg} + {8'h00, blen_reg};
                        phase_next = PH_TYPE;
                    end
                end
                PH_START: begin
                    // first two payload bytes, unsigned, missing ones are zero
                    if (pidx_reg == 2'd0) begin
                        addr_next = {8'h00, b};
                        pidx_next = 2'd1;
                    end else if (pidx_reg == 2'd1) begin
                        addr_next = {b, addr_reg[7:0]};
                        pidx_next = 2'd2;
                    end
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        n_res = 2'd1;
                        res0.event_kind    = EV_START_ADDR;
                        res0.first_address = addr_next;
                        phase_next = PH_TYPE;
                    end
                end
                default: begin
                    phase_next = PH_TYPE;
                end
            endcase
        end

        res0.last_of_run = (n_res == 2'd1);
    end

    // Event queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (proc_fire) begin
                wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            end
            count_reg <= count_reg + (proc_fire ? RES_CNT_W'(n_res) : '0)
                         - RES_CNT_W'(pop);
        end
    end

    // Event queue storage
    always_ff @(posedge aclk) begin
        if (proc_fire && n_res != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (proc_fire && n_res == 2'd2) begin
            queue_reg[wr_ptr_reg + RES_PTR_W'(1)] <= res1;
        end
    end

endmodule

`default_nettype wire

// ===== src/clrp_checker.sv =====
// Port-level checks for the record parser, bound to the top level.
`default_nettype none

`include "cmd_load_record_parser_assert.svh"

module clrp_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  m_valid,
    input wire                  m_ready,
    input clrp_pkg::out_beat_t  m_data
);
    import clrp_pkg::*;

    // A waiting event holds still
    `CLRP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "event changed while stalled")

    // Only name bytes and unknown types carry a byte
    `CLRP_ASSERT_NOW(a_byte_zero, aclk, aresetn, m_valid && m_data.event_kind != EV_NAME_BYTE && m_data.event_kind != EV_UNKNOWN, m_data.event_byte == '0, "stray event byte")

    // Only load blocks carry an end address
    `CLRP_ASSERT_NOW(a_end_zero, aclk, aresetn, m_valid && m_data.event_kind != EV_LOAD_BLOCK, m_data.end_address == '0, "stray end address")

    // A load block spans 1 to 256 bytes
    `CLRP_ASSERT_NOW(a_block_span, aclk, aresetn, m_valid && m_data.event_kind == EV_LOAD_BLOCK, (m_data.end_address > {1'b0, m_data.first_address}) && (m_data.end_address <= {1'b0, m_data.first_address} + 17'd256), "bad load block span")

endmodule

bind cmd_load_record_parser clrp_checker u_clrp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== tb/cmd_load_record_parser_tb.sv =====
// Self-checking testbench for the load-module record parser.
`timescale 1ns / 1ps

module cmd_load_record_parser_tb;
    import clrp_pkg::*;

    localparam int NUM_ITEMS   = 1450;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_DIR     = 26;

    // One row of the directed table; ev is only meaningful when typed is set
    typedef struct packed {
        in_beat_t  beat;
        logic      typed;
        out_beat_t ev;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    cmd_load_record_parser u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Parser shadow state
    phase_t      prs_phase   = PH_TYPE;
    rec_kind_t   prs_kind    = RK_NONE;
    logic [8:0]  prs_left    = '0;
    logic [8:0]  prs_blk_len = '0;
    logic [15:0] prs_addr    = '0;
    logic [1:0]  prs_idx     = '0;
    bit          prs_halt    = 1'b0;

    out_beat_t   events_due [$];
    stim_row_t   dir_rows [0:NUM_DIR-1];
    int          errors      = 0;
    int          bytes_sent  = 0;
    int          cycle_count = 0;
    int          send_burst  = 0;
    bit          sink_hold   = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cmd_load_record_parser_tb: errors");
            $finish;
        end
    end

    function automatic out_beat_t mk_ev(input ev_kind_t kind, input logic [7:0] ebyte,
                                        input logic [15:0] first, input logic [16:0] endv);
        out_beat_t e;
        e.event_kind    = kind;
        e.event_byte    = ebyte;
        e.first_address = first;
        e.end_address   = endv;
        e.last_of_run   = 1'b0;
        return e;
    endfunction

    function automatic in_beat_t beat(input logic [7:0] b, input logic eos);
        in_beat_t x;
        x.data_byte     = b;
        x.end_of_stream = eos;
        return x;
    endfunction

    // Directed rows: rb is checked by the parser shadow, rt carries its event
    function automatic stim_row_t rb(input logic [7:0] b);
        stim_row_t row;
        row.beat  = beat(b, 1'b0);
        row.typed = 1'b0;
        row.ev    = '0;
        return row;
    endfunction

    function automatic stim_row_t rt(input logic [7:0] b, input logic eos, input ev_kind_t kind,
                                     input logic [7:0] ebyte, input logic [15:0] first,
                                     input logic [16:0] endv);
        stim_row_t row;
        row.beat  = beat(b, eos);
        row.typed = 1'b1;
        row.ev    = mk_ev(kind, ebyte, first, endv);
        row.ev.last_of_run = 1'b1;
        return row;
    endfunction

    // Advance the parser shadow by one beat; returns the number of events
    function automatic int parse_byte(input in_beat_t x, output out_beat_t e0,
                                      output out_beat_t e1);
        logic [7:0] b;
        logic [7:0] len8;
        out_beat_t  evs [0:1];
        int         n;
        b      = x.data_byte;
        n      = 0;
        evs[0] = '0;
        evs[1] = '0;
        if (x.end_of_stream) begin
            evs[0] = mk_ev((prs_halt || prs_phase == PH_TYPE) ? EV_CLEAN_END : EV_TRUNC_END,
                           8'h00, 16'h0000, 17'h0);
            n = 1;
            prs_phase   = PH_TYPE;
            prs_kind    = RK_NONE;
            prs_left    = '0;
            prs_blk_len = '0;
            prs_addr    = '0;
            prs_idx     = '0;
            prs_halt    = 1'b0;
        end else if (!prs_halt) begin
            case (prs_phase)
                PH_TYPE: begin
                    if (b == TYPE_NAME) begin
                        prs_kind = RK_NAME; prs_phase = PH_LEN;
                    end else if (b == TYPE_LOAD) begin
                        prs_kind = RK_LOAD; prs_phase = PH_LEN;
                    end else if (b == TYPE_START) begin
                        prs_kind = RK_START; prs_phase = PH_LEN;
                    end else begin
                        prs_halt = 1'b1;
                        evs[n] = mk_ev(EV_UNKNOWN, b, 16'h0000, 17'h0); n++;
                    end
                end
                PH_LEN: begin
                    prs_addr = '0;
                    prs_idx  = '0;
                    case (prs_kind)
                        RK_NAME: begin
                            if (b == 8'h00) begin
                                evs[n] = mk_ev(EV_NAME_END, 8'h00, 16'h0000, 17'h0); n++;
                                prs_phase = PH_TYPE;
                            end else begin
                                prs_left = {1'b0, b}; prs_phase = PH_NAME;
                            end
                        end
                        RK_LOAD: begin
                            // length byte counts the two address bytes; a remainder of 0 means a full 256
                            len8 = b - LOAD_LEN_BIAS;
                            prs_blk_len = (len8 == 8'h00) ? LOAD_LEN_FULL : {1'b0, len8};
                            prs_left    = prs_blk_len;
                            prs_phase   = PH_LADDR;
                        end
                        RK_START: begin
                            if (b == 8'h00) begin
                                evs[n] = mk_ev(EV_START_ADDR, 8'h00, 16'h0000, 17'h0); n++;
                                prs_phase = PH_TYPE;
                            end else begin
                                prs_left = {1'b0, b}; prs_phase = PH_START;
                            end
                        end
                        default: prs_phase = PH_TYPE;
                    endcase
                end
                PH_NAME: begin
                    evs[n] = mk_ev(EV_NAME_BYTE, b, 16'h0000, 17'h0); n++;
                    prs_left = prs_left - 9'd1;
                    if (prs_left == 9'd0) begin
                        evs[n] = mk_ev(EV_NAME_END, 8'h00, 16'h0000, 17'h0); n++;
                        prs_phase = PH_TYPE;
                    end
                end
                PH_LADDR: begin
                    if (prs_idx == 2'd0) begin
                        prs_addr = {8'h00, b}; prs_idx = 2'd1;
                    end else begin
                        prs_addr[15:8] = b; prs_idx = 2'd2; prs_phase = PH_LDATA;
                    end
                end
                PH_LDATA: begin
                    prs_left = prs_left - 9'd1;
                    if (prs_left == 9'd0) begin
                        evs[n] = mk_ev(EV_LOAD_BLOCK, 8'h00, prs_addr,
                                       {1'b0, prs_addr} + {8'h00, prs_blk_len});
                        n++;
                        prs_phase = PH_TYPE;
                    end
                end
                PH_START: begin
                    // bytes past the second are skipped; missing ones stay zero
                    if (prs_idx == 2'd0) begin
                        prs_addr = {8'h00, b}; prs_idx = 2'd1;
                    end else if (prs_idx == 2'd1) begin
                        prs_addr[15:8] = b; prs_idx = 2'd2;
                    end
                    prs_left = prs_left - 9'd1;
                    if (prs_left == 9'd0) begin
                        evs[n] = mk_ev(EV_START_ADDR, 8'h00, prs_addr, 17'h0); n++;
                        prs_phase = PH_TYPE;
                    end
                end
                default: prs_phase = PH_TYPE;
            endcase
        end
        if (n > 0)
            evs[n-1].last_of_run = 1'b1;
        e0 = evs[0];
        e1 = evs[1];
        return n;
    endfunction

    // Sender gap: mostly short, some long, with bursts of back-to-back beats
    function automatic int idle_gap();
        int r;
        if (sink_hold)
            return 0;
        if (send_burst > 0) begin
            send_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            send_burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic void cmp_field(input string fname, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fname, want, got);
        end
    endfunction

    task automatic check_event(input out_beat_t got);
        out_beat_t want;
        if (events_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected event: expected none, got kind %0d byte 0x%0h",
                     $time, got.event_kind, got.event_byte);
        end else begin
            want = events_due.pop_front();
            cmp_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
            cmp_field("event_byte", 32'(want.event_byte), 32'(got.event_byte));
            cmp_field("first_address", 32'(want.first_address), 32'(got.first_address));
            cmp_field("end_address", 32'(want.end_address), 32'(got.end_address));
            cmp_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        end
    endtask

    // Offer one beat after a random gap; expectations are queued before it can emerge
    task automatic send_beat(input in_beat_t x, input bit typed = 1'b0,
                             input out_beat_t want = '0);
        int        gap;
        int        n;
        out_beat_t e0;
        out_beat_t e1;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (!prs_halt || x.end_of_stream)
            bytes_sent++;
        n = parse_byte(x, e0, e1);
        if (typed) begin
            events_due.push_back(want);
        end else begin
            if (n > 0) events_due.push_back(e0);
            if (n > 1) events_due.push_back(e1);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (events_due.size() != 0);
    endtask

    // One random record: mostly well formed, the rest lone end marks, truncated or bad type
    task automatic send_record();
        int          r;
        int          len;
        int          k;
        logic [7:0]  tb_type;
        logic [15:0] start;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            len = ($urandom_range(0, 99) < 2) ? $urandom_range(9, 255) : $urandom_range(0, 8);
            send_beat(beat(TYPE_NAME, 1'b0));
            send_beat(beat(8'(len), 1'b0));
            for (k = 0; k < len; k++)
                send_beat(beat(8'($urandom), 1'b0));
        end else if (r < 55) begin
            len = ($urandom_range(0, 99) < 4) ? $urandom_range(5, 30) : $urandom_range(0, 4);
            send_beat(beat(TYPE_START, 1'b0));
            send_beat(beat(8'(len), 1'b0));
            for (k = 0; k < len; k++)
                send_beat(beat(8'($urandom), 1'b0));
        end else if (r < 82) begin
            // payload lengths near the 256 wrap are rare, they cost many beats
            len = ($urandom_range(0, 99) < 2) ? $urandom_range(250, 256) : $urandom_range(1, 10);
            start = ($urandom_range(0, 9) == 0) ? {8'hFF, 8'($urandom)} : 16'($urandom);
            send_beat(beat(TYPE_LOAD, 1'b0));
            send_beat(beat(8'(len + 2), 1'b0));
            send_beat(beat(start[7:0], 1'b0));
            send_beat(beat(start[15:8], 1'b0));
            for (k = 0; k < len; k++)
                send_beat(beat(8'($urandom), 1'b0));
        end else if (r < 88) begin
            send_beat(beat(8'($urandom), 1'b1));
        end else if (r < 95) begin
            k = $urandom_range(0, 2);
            tb_type = (k == 0) ? TYPE_NAME : (k == 1) ? TYPE_LOAD : TYPE_START;
            send_beat(beat(tb_type, 1'b0));
            len = $urandom_range(0, 4);
            for (k = 0; k < len; k++)
                send_beat(beat(8'($urandom), 1'b0));
            send_beat(beat(8'($urandom), 1'b1));
        end else begin
            do tb_type = 8'($urandom);
            while (tb_type == TYPE_NAME || tb_type == TYPE_LOAD || tb_type == TYPE_START);
            send_beat(beat(tb_type, 1'b0));
            len = $urandom_range(0, 5);
            for (k = 0; k < len; k++)
                send_beat(beat(8'($urandom), 1'b0));
            send_beat(beat(8'($urandom), 1'b1));
        end
    endtask

    // Event sink: random backpressure, plus one long hold on request
    initial begin : result_sink
        int r;
        int run;
        bit ready_now;
        run       = 0;
        ready_now = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                check_event(m_data);
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_hold = 1'b0;
                run = 0;
            end else begin
                if (run == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 55) begin
                        ready_now = 1'b1;
                        run = $urandom_range(1, 24);
                    end else begin
                        ready_now = 1'b0;
                        run = (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                    end
                end
                run--;
                m_ready <= ready_now;
            end
        end
    end

    // Stimulus: reset, directed table, then random records
    initial begin : stimulus
        bit hold_fired;
        bit pause_fired;
        hold_fired  = 1'b0;
        pause_fired = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        dir_rows = '{
            rt(8'h5A, 1'b1, EV_CLEAN_END, 8'h00, 16'h0000, 17'h0),   // end right after reset
            rb(TYPE_NAME),
            rt(8'h00, 1'b0, EV_NAME_END, 8'h00, 16'h0000, 17'h0),    // empty name
            rb(TYPE_NAME),
            rb(8'h01),
            rb(8'hFF),
            rb(TYPE_START),
            rt(8'h00, 1'b0, EV_START_ADDR, 8'h00, 16'h0000, 17'h0),  // empty start record
            rb(TYPE_START),
            rb(8'h02),
            rb(8'h80),
            rt(8'hFF, 1'b0, EV_START_ADDR, 8'h00, 16'hFF80, 17'h0),  // high bytes stay unsigned
            rb(TYPE_START),
            rb(8'h01),
            rt(8'hAB, 1'b0, EV_START_ADDR, 8'h00, 16'h00AB, 17'h0),  // missing high byte
            rb(TYPE_LOAD),
            rb(8'h03),
            rb(8'hFF),
            rb(8'hFF),
            rt(8'h00, 1'b0, EV_LOAD_BLOCK, 8'h00, 16'hFFFF, 17'h10000),
            rb(TYPE_LOAD),
            rb(8'h05),
            rt(8'h00, 1'b1, EV_TRUNC_END, 8'h00, 16'h0000, 17'h0),   // cut inside a record
            rt(8'hFF, 1'b0, EV_UNKNOWN, 8'hFF, 16'h0000, 17'h0),
            rb(TYPE_NAME),                                           // ignored while halted
            rt(8'h00, 1'b1, EV_CLEAN_END, 8'h00, 16'h0000, 17'h0)
        };
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].ev);

        while (bytes_sent < NUM_ITEMS) begin
            if (!hold_fired && bytes_sent >= 400) begin
                hold_fired = 1'b1;
                sink_hold  = 1'b1;
            end
            if (!pause_fired && bytes_sent >= 900) begin
                pause_fired = 1'b1;
                wait_drained();
            end
            send_record();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && events_due.size() == 0)
            $display("cmd_load_record_parser_tb: clean");
        else
            $display("cmd_load_record_parser_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/clrp_pkg.sv
src/cmd_load_record_parser.sv
src/clrp_checker.sv
tb/cmd_load_record_parser_tb.sv
